>>> sv/rrp_pkg.sv
// Shared types, constants and a helper function for the RESP request parser.
`timescale 1ns / 1ps

package rrp_pkg;

  // Numeric limits and widths.
  localparam int unsigned NUM_W = 31;
  localparam logic [NUM_W-1:0] NUM_MAX = 31'h7FFF_FFFF;

  // Result queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);

  // Characters that the parser recognizes.
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ARG_DONE = 2'd1;
  localparam logic [1:0] KIND_MSG_OK = 2'd2;
  localparam logic [1:0] KIND_MSG_ERR = 2'd3;

  // Error codes carried with a failing message status.
  localparam logic [2:0] ERR_NO_STAR = 3'd0;
  localparam logic [2:0] ERR_EARLY_END = 3'd1;
  localparam logic [2:0] ERR_COUNT_LOW = 3'd2;
  localparam logic [2:0] ERR_NO_DOLLAR = 3'd3;
  localparam logic [2:0] ERR_LEN_MISMATCH = 3'd4;
  localparam logic [2:0] ERR_TOO_MANY = 3'd5;
  localparam logic [2:0] ERR_TOO_FEW = 3'd6;

  // Parser phases, one-hot.
  typedef enum logic [7:0] {
    PH_STAR     = 8'b0000_0001,
    PH_HDR_DIG  = 8'b0000_0010,
    PH_HDR_REST = 8'b0000_0100,
    PH_GAP_LEN  = 8'b0000_1000,
    PH_LEN_DIG  = 8'b0001_0000,
    PH_LEN_REST = 8'b0010_0000,
    PH_GAP_PAY  = 8'b0100_0000,
    PH_PAY      = 8'b1000_0000
  } phase_t;

  // One result item as it travels through the queue.
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       payload_byte;
    logic [NUM_W-1:0] arg_index;
    logic [NUM_W-1:0] arg_length;
    logic [NUM_W-1:0] arg_count;
    logic [2:0]       error_code;
    logic             last_of_run;
  } result_t;

  // Appends one decimal digit to a number, saturating at NUM_MAX.
  function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] v,
                                                 input logic [3:0] d);
    logic [NUM_W+3:0] w;
    w = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {{NUM_W{1'b0}}, d};
    return (w > {4'd0, NUM_MAX}) ? NUM_MAX : w[NUM_W-1:0];
  endfunction

endpackage

>>> sv/rrp_if.sv
// Channel interfaces for the request bytes and the parse results.
`timescale 1ns / 1ps

interface rrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface rrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [30:0] arg_index;
  logic [30:0] arg_length;
  logic [30:0] arg_count;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output kind, output payload_byte, output arg_index,
                  output arg_length, output arg_count, output error_code,
                  output last_of_run, input ready);
  modport sink (input valid, input kind, input payload_byte, input arg_index,
                input arg_length, input arg_count, input error_code,
                input last_of_run, output ready);
endinterface

>>> sv/rrp_core.sv
// Parser state and per-byte result generation for the RESP request parser.
`timescale 1ns / 1ps

module rrp_core
  import rrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  output logic [1:0] push_cnt,
  output result_t    res0,
  output result_t    res1
);

  phase_t           phase_r, phase_nxt;
  logic             prev_cr_r, prev_cr_nxt;
  logic [NUM_W-1:0] count_r, count_nxt;
  logic [NUM_W-1:0] args_r, args_nxt;
  logic [NUM_W-1:0] len_r, len_nxt;
  logic [NUM_W-1:0] seen_r, seen_nxt;
  logic [2:0]       ferr_r, ferr_nxt;
  logic             eflag_r, eflag_nxt;

  logic             is_sep;
  logic             is_dig;
  logic [3:0]       digit;
  logic             n_main;
  logic [1:0]       n_res;
  logic [NUM_W-1:0] fidx;
  logic [NUM_W-1:0] flen;
  result_t          status;

  assign is_sep = (data_byte == CH_CR) || (data_byte == CH_LF);
  assign is_dig = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign digit  = data_byte[3:0];

  // Next state and results for the byte presented this cycle.
  always_comb begin
    phase_nxt   = phase_r;
    prev_cr_nxt = prev_cr_r;
    count_nxt   = count_r;
    args_nxt    = args_r;
    len_nxt     = len_r;
    seen_nxt    = seen_r;
    ferr_nxt    = ferr_r;
    eflag_nxt   = eflag_r;
    res0        = '0;
    res1        = '0;
    status      = '0;
    n_main      = 1'b0;
    n_res       = 2'd0;
    fidx        = '0;
    flen        = '0;

    // Token handling while no error is flagged.
    if (!eflag_r) begin
      unique case (phase_r)
        PH_STAR: begin
          if (data_byte == CH_STAR) begin
            phase_nxt   = PH_HDR_DIG;
            count_nxt   = '0;
            prev_cr_nxt = 1'b0;
          end else begin
            eflag_nxt = 1'b1;
            ferr_nxt  = ERR_NO_STAR;
          end
        end
        PH_HDR_DIG, PH_HDR_REST: begin
          if ((data_byte == CH_LF) && prev_cr_r) begin
            prev_cr_nxt = 1'b0;
            if (is_last) begin
              eflag_nxt = 1'b1;
              ferr_nxt  = ERR_EARLY_END;
            end else if (count_r == '0) begin
              eflag_nxt = 1'b1;
              ferr_nxt  = ERR_COUNT_LOW;
            end else begin
              phase_nxt = PH_GAP_LEN;
              args_nxt  = '0;
            end
          end else begin
            if ((phase_r == PH_HDR_DIG) && is_dig) begin
              count_nxt = add_digit(count_r, digit);
            end else begin
              phase_nxt = PH_HDR_REST;
            end
            prev_cr_nxt = (data_byte == CH_CR);
          end
        end
        PH_GAP_LEN: begin
          if (!is_sep) begin
            if (data_byte == CH_DOLLAR) begin
              phase_nxt = PH_LEN_DIG;
              len_nxt   = '0;
            end else begin
              eflag_nxt = 1'b1;
              ferr_nxt  = ERR_NO_DOLLAR;
            end
          end
        end
        PH_LEN_DIG: begin
          if (is_sep) begin
            phase_nxt = PH_GAP_PAY;
          end else if (is_dig) begin
            len_nxt = add_digit(len_r, digit);
          end else begin
            phase_nxt = PH_LEN_REST;
          end
        end
        PH_LEN_REST: begin
          if (is_sep) begin
            phase_nxt = PH_GAP_PAY;
          end
        end
        PH_GAP_PAY: begin
          if (!is_sep) begin
            phase_nxt          = PH_PAY;
            seen_nxt           = {{(NUM_W-1){1'b0}}, 1'b1};
            n_main             = 1'b1;
            res0.kind          = KIND_PAYLOAD;
            res0.payload_byte  = data_byte;
            res0.arg_index     = args_r;
          end
        end
        PH_PAY: begin
          if (is_sep) begin
            if (seen_r != len_r) begin
              eflag_nxt = 1'b1;
              ferr_nxt  = ERR_LEN_MISMATCH;
            end else if (args_r >= count_r) begin
              eflag_nxt = 1'b1;
              ferr_nxt  = ERR_TOO_MANY;
            end else begin
              n_main          = 1'b1;
              res0.kind       = KIND_ARG_DONE;
              res0.arg_index  = args_r;
              res0.arg_length = len_r;
              args_nxt        = args_r + 1'b1;
              phase_nxt       = PH_GAP_LEN;
            end
          end else begin
            if (seen_r < NUM_MAX) begin
              seen_nxt = seen_r + 1'b1;
            end
            n_main            = 1'b1;
            res0.kind         = KIND_PAYLOAD;
            res0.payload_byte = data_byte;
            res0.arg_index    = args_r;
          end
        end
        default: begin
          phase_nxt = PH_STAR;
        end
      endcase
    end

    n_res = {1'b0, n_main};

    // End of message: final checks, status result and return to reset state.
    if (is_last) begin
      if (!eflag_nxt) begin
        unique case (phase_nxt)
          PH_GAP_LEN: begin
            if (args_nxt != count_nxt) begin
              eflag_nxt = 1'b1;
              ferr_nxt  = ERR_TOO_FEW;
            end
          end
          PH_LEN_DIG, PH_LEN_REST, PH_GAP_PAY: begin
            eflag_nxt = 1'b1;
            ferr_nxt  = ERR_LEN_MISMATCH;
          end
          PH_PAY: begin
            if (seen_nxt != len_nxt) begin
              eflag_nxt = 1'b1;
              ferr_nxt  = ERR_LEN_MISMATCH;
            end else if (args_nxt >= count_nxt) begin
              eflag_nxt = 1'b1;
              ferr_nxt  = ERR_TOO_MANY;
            end else begin
              // The last argument passes; its completion folds into the status.
              fidx = args_nxt;
              flen = len_nxt;
              if ((args_nxt + 1'b1) != count_nxt) begin
                eflag_nxt = 1'b1;
                ferr_nxt  = ERR_TOO_FEW;
              end
            end
          end
          default: begin
            eflag_nxt = 1'b1;
            ferr_nxt  = ERR_EARLY_END;
          end
        endcase
      end

      status.kind        = eflag_nxt ? KIND_MSG_ERR : KIND_MSG_OK;
      status.arg_index   = fidx;
      status.arg_length  = flen;
      status.arg_count   = count_nxt;
      status.error_code  = eflag_nxt ? ferr_nxt : 3'd0;
      status.last_of_run = 1'b1;
      if (n_main) begin
        res1  = status;
        n_res = 2'd2;
      end else begin
        res0  = status;
        n_res = 2'd1;
      end

      phase_nxt   = PH_STAR;
      prev_cr_nxt = 1'b0;
      count_nxt   = '0;
      args_nxt    = '0;
      len_nxt     = '0;
      seen_nxt    = '0;
      ferr_nxt    = '0;
      eflag_nxt   = 1'b0;
    end else if (n_main) begin
      res0.last_of_run = 1'b1;
    end
  end

  assign push_cnt = fire ? n_res : 2'd0;

  // Parser state registers advance once per transfer from the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_STAR;
      prev_cr_r <= 1'b0;
      count_r   <= '0;
      args_r    <= '0;
      len_r     <= '0;
      seen_r    <= '0;
      ferr_r    <= '0;
      eflag_r   <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      prev_cr_r <= prev_cr_nxt;
      count_r   <= count_nxt;
      args_r    <= args_nxt;
      len_r     <= len_nxt;
      seen_r    <= seen_nxt;
      ferr_r    <= ferr_nxt;
      eflag_r   <= eflag_nxt;
    end
  end

  // A final byte always yields a status as the last result of its run.
  a_last_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_last) |->
      ((push_cnt == 2'd1) && (res0.kind == KIND_MSG_OK || res0.kind == KIND_MSG_ERR)) ||
      ((push_cnt == 2'd2) && (res1.kind == KIND_MSG_OK || res1.kind == KIND_MSG_ERR)))
    else $error("final byte did not produce a message status");

  // After a final byte the parser is back in its reset state.
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_last) |=> ((phase_r == PH_STAR) && !eflag_r && (args_r == '0)))
    else $error("parser did not return to reset state after message end");

  // Once an error is flagged, only the final byte produces a result.
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && eflag_r && !is_last) |-> (push_cnt == 2'd0))
    else $error("result produced after an error was flagged");

endmodule

>>> sv/rrp_fifo.sv
// Small result queue taking up to two results per cycle and giving one.
`timescale 1ns / 1ps

module rrp_fifo
  import rrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  result_t    din0,
  input  result_t    din1,
  input  logic       pop,
  output result_t    head,
  output logic       not_empty,
  output logic       room2
);

  localparam logic [FIFO_AW:0] DEPTH_C = (FIFO_AW + 1)'(FIFO_DEPTH);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic [FIFO_AW+1:0] cnt_sum;
  logic [FIFO_AW-1:0] wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + 1'b1;
  assign cnt_sum    = {1'b0, cnt_r} + {{FIFO_AW{1'b0}}, push_cnt} -
                      {{(FIFO_AW+1){1'b0}}, pop};
  assign cnt_nxt    = cnt_sum[FIFO_AW:0];
  assign wr_ptr_nxt = wr_ptr_r + push_cnt[FIFO_AW-1:0];
  assign rd_ptr_nxt = rd_ptr_r + {{(FIFO_AW-1){1'b0}}, pop};

  assign head      = mem[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= (DEPTH_C - 2'd2));

  // Storage writes for one or two results.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= din0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= din1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Pushes never overrun the queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_sum <= {1'b0, DEPTH_C})
    else $error("result queue overflow");

  // Pops only happen with something stored.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("result queue underflow");

  // Two results are pushed only when room for two was reported.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt == 2'd2) |-> (cnt_r <= DEPTH_C - 2'd2))
    else $error("push without room");

endmodule

>>> sv/resp_request_parser.sv
// Top level of the RESP multibulk request parser: input stage, parser and result queue.
// A byte is held in the input register and its results in the queue before output.
// Throughput: one byte per cycle while the queue has room for two results and each
// byte yields at most one result; two results leave the single-result port one by one.
// Reset (rst_n low, synchronous) clears the input stage, parser state and queue;
// the parser also returns to its reset state after each final byte.
`timescale 1ns / 1ps

module resp_request_parser
  import rrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rrp_in_if.sink    in_ch,
  rrp_out_if.source out_ch
);

  logic       stg_valid_r;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;
  logic       stg_fire;
  logic       in_xfer;
  logic       room2;
  logic       not_empty;
  logic       pop;
  logic [1:0] push_cnt;
  result_t    res0;
  result_t    res1;
  result_t    head;

  // The stage hands its byte to the parser when the queue has room for two results.
  assign stg_fire    = stg_valid_r && room2;
  assign in_ch.ready = !stg_valid_r || stg_fire;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_byte_r <= in_ch.data_byte;
      stg_last_r <= in_ch.is_last;
    end
  end

  rrp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (stg_fire),
    .data_byte (stg_byte_r),
    .is_last   (stg_last_r),
    .push_cnt  (push_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  assign pop = out_ch.valid && out_ch.ready;

  rrp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .din0      (res0),
    .din1      (res1),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  // Result channel driven from the queue head.
  assign out_ch.valid        = not_empty;
  assign out_ch.kind         = head.kind;
  assign out_ch.payload_byte = head.payload_byte;
  assign out_ch.arg_index    = head.arg_index;
  assign out_ch.arg_length   = head.arg_length;
  assign out_ch.arg_count    = head.arg_count;
  assign out_ch.error_code   = head.error_code;
  assign out_ch.last_of_run  = head.last_of_run;

  // The stage only drops its byte toward the parser when it holds one.
  a_fire_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
    stg_fire |-> stg_valid_r)
    else $error("parser fired without a staged byte");

  // A stalled stage keeps its byte until the parser takes it.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid_r && !stg_fire) |=> (stg_valid_r && $stable(stg_byte_r) &&
                                    $stable(stg_last_r)))
    else $error("staged byte lost while stalled");

  // Every byte handed to the parser that produced a result yields an offer next cycle.
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |=> out_ch.valid)
    else $error("pushed result not offered");

endmodule
